>>> rtl/core/aging_priority_task_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Aging priority task scheduler assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef AGING_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define AGING_PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Checked only while reset is released.
`define APTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define APTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/apts_pkg.sv
// ----------------------------------------------------------------------------
// Aging priority task scheduler package
// Widths, command and status codes, queue entry types and priority helpers.
// ----------------------------------------------------------------------------
package apts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int POS_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int SLOT_W    = 4;
    localparam int PRIO_W    = 6;

    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam prio_t PRIO_MAX       = 6'sd20;
    localparam prio_t PRIO_MIN       = -6'sd20;
    localparam prio_t PRIO_ABOVE_ALL = 6'sd21;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_SET_PRIO = 2'd2,
        CMD_PICK     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_DUP    = 3'd2,
        STAT_ABSENT = 3'd3,
        STAT_FULL   = 3'd4
    } status_t;

    typedef struct packed {
        slot_t task_id;
        prio_t static_prio;
        prio_t dynamic_prio;
    } entry_t;

    typedef enum logic [1:0] {
        SRC_KEEP,
        SRC_NEXT,
        SRC_NEW
    } src_t;

    typedef struct packed {
        src_t src;
        logic age;
    } cell_ctl_t;

    function automatic prio_t clamp_prio(input prio_t raw);
        prio_t res;
        res = raw;
        if (raw > PRIO_MAX)
        begin
            res = PRIO_MAX;
        end
        else if (raw < PRIO_MIN)
        begin
            res = PRIO_MIN;
        end
        return res;
    endfunction

    function automatic prio_t age_prio(input prio_t p);
        prio_t res;
        res = p;
        if (p > PRIO_MIN)
        begin
            res = p - 6'sd1;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/apts_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one ready queue entry and loads it from itself, its neighbor toward
// the tail or the broadcast entry, aging the dynamic priority on request.
// ----------------------------------------------------------------------------
module apts_cell
    import apts_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    next_entry,
    input  entry_t    new_entry,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t src_entry;

    always_comb
    begin
        case (ctl.src)
            SRC_NEXT: src_entry = next_entry;
            SRC_NEW:  src_entry = new_entry;
            default:  src_entry = entry_reg;
        endcase
        entry_next = src_entry;
        if (ctl.age)
        begin
            entry_next.dynamic_prio = age_prio(src_entry.dynamic_prio);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/core/apts_min_tree.sv
// ----------------------------------------------------------------------------
// Minimum search tree
// Finds the position of the lowest dynamic priority; on a tie the lower
// position wins.
// ----------------------------------------------------------------------------
module apts_min_tree
    import apts_pkg::*;
(
    input  prio_t dyn [MAX_TASKS],
    output pos_t  min_pos
);

    localparam int LEVELS = (POS_W < 1) ? 1 : POS_W;
    localparam int LEAVES = 1 << LEVELS;

    prio_t node_prio [LEVELS+1][LEAVES];
    pos_t  node_pos  [LEVELS+1][LEAVES];

    always_comb
    begin
        for (int l = 0; l <= LEVELS; l++)
        begin
            for (int n = 0; n < LEAVES; n++)
            begin
                node_prio[l][n] = PRIO_ABOVE_ALL;
                node_pos[l][n]  = '0;
            end
        end
        for (int n = 0; n < LEAVES; n++)
        begin
            node_pos[0][n] = pos_t'(n);
            if (n < MAX_TASKS)
            begin
                node_prio[0][n] = dyn[n];
            end
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int n = 0; n < (LEAVES >> (l + 1)); n++)
            begin
                if (node_prio[l][2*n+1] < node_prio[l][2*n])
                begin
                    node_prio[l+1][n] = node_prio[l][2*n+1];
                    node_pos[l+1][n]  = node_pos[l][2*n+1];
                end
                else
                begin
                    node_prio[l+1][n] = node_prio[l][2*n];
                    node_pos[l+1][n]  = node_pos[l][2*n];
                end
            end
        end
    end

    assign min_pos = node_pos[LEVELS][0];

endmodule

>>> rtl/core/aging_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Aging priority task scheduler
// Ordered ready queue held in a chain of cells, head at cell zero. Commands
// add, remove, set priority and pick the most urgent entry with aging.
// ----------------------------------------------------------------------------
// Channel   | Handshake           | Payload
// command   | start, busy         | command, task_slot, priority_req
// result    | done (strobe)       | status, chosen_task, chosen_priority
//
// Each command has an evaluation state, for the slot match and the minimum
// search over all cells, then an update state, in which the chain loads or
// shifts its entries and, on a pick, ages them. A new command is accepted in
// the update state. The result appears in the cycle after the update.
// Reset empties the queue at once; there is no clearing pass.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "aging_priority_task_scheduler_macros.svh"

module aging_priority_task_scheduler
    import apts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic [SLOT_W-1:0]        task_slot,
    input  logic signed [PRIO_W-1:0] priority_req,
    output logic                     done,
    output logic [2:0]               status,
    output logic [SLOT_W-1:0]        chosen_task,
    output logic signed [PRIO_W-1:0] chosen_priority
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    cnt_t      count_reg;
    cnt_t      count_next;
    logic      done_reg;
    cmd_t      cmd_reg;
    slot_t     slot_reg;
    prio_t     prio_reg;
    logic      found_reg;
    pos_t      pos_reg;
    pos_t      win_pos_reg;
    status_t   status_reg;
    slot_t     chosen_task_reg;
    prio_t     chosen_prio_reg;

    logic      accept;
    logic      apply_ok;
    status_t   status_next;
    entry_t    cell_entry [MAX_TASKS];
    cell_ctl_t cell_ctl   [MAX_TASKS];
    prio_t     tree_dyn   [MAX_TASKS];
    logic [MAX_TASKS-1:0] match;
    pos_t      match_pos;
    pos_t      tree_pos;
    entry_t    new_entry;
    entry_t    win_entry;

    assign busy   = (state_reg == S_EVAL);
    assign accept = start && !busy;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            if (gi < MAX_TASKS - 1)
            begin : g_mid
                apts_cell u_cell (
                    .clk        (clk),
                    .ctl        (cell_ctl[gi]),
                    .next_entry (cell_entry[gi+1]),
                    .new_entry  (new_entry),
                    .entry      (cell_entry[gi])
                );
            end
            else
            begin : g_last
                apts_cell u_cell (
                    .clk        (clk),
                    .ctl        (cell_ctl[gi]),
                    .next_entry (cell_entry[gi]),
                    .new_entry  (new_entry),
                    .entry      (cell_entry[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            match[i]    = (cnt_t'(i) < count_reg) && (cell_entry[i].task_id == slot_reg);
            tree_dyn[i] = (cnt_t'(i) < count_reg) ? cell_entry[i].dynamic_prio
                                                  : PRIO_ABOVE_ALL;
            if (match[i])
            begin
                match_pos = match_pos | pos_t'(i);
            end
        end
    end

    apts_min_tree u_min_tree (
        .dyn     (tree_dyn),
        .min_pos (tree_pos)
    );

    assign win_entry = cell_entry[win_pos_reg];

    always_comb
    begin
        status_next = STAT_OK;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (found_reg)
                begin
                    status_next = STAT_DUP;
                end
                else if (count_reg == cnt_t'(MAX_TASKS))
                begin
                    status_next = STAT_FULL;
                end
            end
            CMD_REMOVE, CMD_SET_PRIO:
            begin
                if (!found_reg)
                begin
                    status_next = STAT_ABSENT;
                end
            end
            CMD_PICK:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            default: status_next = STAT_OK;
        endcase
    end

    assign apply_ok = (state_reg == S_APPLY) && (status_next == STAT_OK);

    always_comb
    begin
        if (cmd_reg == CMD_PICK)
        begin
            new_entry.task_id      = win_entry.task_id;
            new_entry.static_prio  = win_entry.static_prio;
            new_entry.dynamic_prio = win_entry.static_prio;
        end
        else
        begin
            new_entry.task_id      = slot_reg;
            new_entry.static_prio  = prio_reg;
            new_entry.dynamic_prio = prio_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            cell_ctl[i].src = SRC_KEEP;
            cell_ctl[i].age = 1'b0;
            if (apply_ok)
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (cnt_t'(i) == count_reg)
                        begin
                            cell_ctl[i].src = SRC_NEW;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (pos_t'(i) >= pos_reg)
                        begin
                            cell_ctl[i].src = SRC_NEXT;
                        end
                    end
                    CMD_SET_PRIO:
                    begin
                        if (pos_t'(i) == pos_reg)
                        begin
                            cell_ctl[i].src = SRC_NEW;
                        end
                    end
                    CMD_PICK:
                    begin
                        if (cnt_t'(i + 1) == count_reg)
                        begin
                            cell_ctl[i].src = SRC_NEW;
                        end
                        else if (pos_t'(i) >= win_pos_reg)
                        begin
                            cell_ctl[i].src = SRC_NEXT;
                            cell_ctl[i].age = 1'b1;
                        end
                        else
                        begin
                            cell_ctl[i].age = 1'b1;
                        end
                    end
                    default: cell_ctl[i].src = SRC_KEEP;
                endcase
            end
        end
        if (apply_ok && (cmd_reg == CMD_ADD))
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (apply_ok && (cmd_reg == CMD_REMOVE))
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EVAL : S_IDLE;
            S_EVAL:  state_next = S_APPLY;
            S_APPLY: state_next = start ? S_EVAL : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            slot_reg <= task_slot;
            prio_reg <= clamp_prio(priority_req);
        end
        if (state_reg == S_EVAL)
        begin
            found_reg   <= |match;
            pos_reg     <= match_pos;
            win_pos_reg <= tree_pos;
        end
        if (state_reg == S_APPLY)
        begin
            status_reg <= status_next;
            if (apply_ok && (cmd_reg == CMD_PICK))
            begin
                chosen_task_reg <= win_entry.task_id;
                chosen_prio_reg <= win_entry.static_prio;
            end
            else
            begin
                chosen_task_reg <= '0;
                chosen_prio_reg <= '0;
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign chosen_task     = chosen_task_reg;
    assign chosen_priority = chosen_prio_reg;

    `APTS_ASSERT(a_count_bound, count_reg <= cnt_t'(MAX_TASKS), "Queue count exceeds capacity.")
    `APTS_ASSERT(a_done_after_apply, (state_reg == S_APPLY) |=> done_reg, "Result strobe missing after update.")
    `APTS_ASSERT(a_no_spurious_done, (state_reg != S_APPLY) |=> !done_reg, "Result strobe without an update.")
    `APTS_ASSERT(a_add_grows, (apply_ok && (cmd_reg == CMD_ADD)) |=> (count_reg == $past(count_reg) + cnt_t'(1)), "Successful add did not grow the queue.")
    `APTS_ASSERT(a_fail_no_choice, (done_reg && (status_reg != STAT_OK)) |-> ((chosen_task_reg == '0) && (chosen_prio_reg == '0)), "Failed command reports a chosen task.")

endmodule
